// ===== hw/rtl/u8dec_pkg.sv =====
// Shared types and constants of the UTF-8 stream validating decoder.
package u8dec_pkg;

  // Byte classes found by the front end.
  typedef enum logic [2:0] {
    K_ASCII = 3'd0,
    K_LEAD2 = 3'd1,
    K_LEAD3 = 3'd2,
    K_LEAD4 = 3'd3,
    K_CONT  = 3'd4,
    K_BAD   = 3'd5
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_TRUNC   = 2'd2
  } status_e;

  localparam logic [20:0] CpReplacement = 21'h00FFFD;
  localparam logic [7:0]  ByteEd        = 8'hED;
  localparam logic [7:0]  MaskSurr      = 8'hA0;

  // One classified byte as it travels from the front end to the back end.
  typedef struct packed {
    kind_e      kind;
    logic       is_ed;
    logic       a0_set;
    logic [6:0] payload;
    logic       eos;
  } cls_t;

  // One result item.
  typedef struct packed {
    logic [20:0] code_point;
    status_e     status;
    logic        string_valid;
    logic        string_done;
  } res_t;

endpackage

// ===== hw/rtl/u8dec_fifo.sv =====
// Small first-in first-out queue built from flip-flops.
module u8dec_fifo #(
  parameter type         T     = logic,
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  T     wr_data_i,
  output logic full_o,
  input  logic rd_en_i,
  output T     rd_data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  T              mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            wr, rd;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign wr        = wr_en_i && !full_o;
  assign rd        = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr && !rd) begin
      count_d = count_q + 1'b1;
    end else if (rd && !wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hw/rtl/u8dec_front.sv =====
// Front end: accepts raw bytes, classifies them and queues the classes.
module u8dec_front #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [7:0]      byte_i,
  input  logic            eos_i,
  output logic            full_o,
  output u8dec_pkg::cls_t cls_o,
  output logic            cls_valid_o,
  input  logic            cls_ready_i
);

  u8dec_pkg::cls_t cls_in;
  logic            cls_empty;

  always_comb begin
    cls_in.eos     = eos_i;
    cls_in.is_ed   = (byte_i == u8dec_pkg::ByteEd);
    cls_in.a0_set  = ((byte_i & u8dec_pkg::MaskSurr) == u8dec_pkg::MaskSurr);
    cls_in.kind    = u8dec_pkg::K_BAD;
    cls_in.payload = '0;
    if (byte_i == 8'h00) begin
      // A NUL lead byte is rejected.
      cls_in.kind = u8dec_pkg::K_BAD;
    end else if (!byte_i[7]) begin
      cls_in.kind    = u8dec_pkg::K_ASCII;
      cls_in.payload = byte_i[6:0];
    end else if (byte_i[7:6] == 2'b10) begin
      cls_in.kind    = u8dec_pkg::K_CONT;
      cls_in.payload = {1'b0, byte_i[5:0]};
    end else if (byte_i[7:5] == 3'b110) begin
      cls_in.kind    = u8dec_pkg::K_LEAD2;
      cls_in.payload = {2'b00, byte_i[4:0]};
    end else if (byte_i[7:4] == 4'b1110) begin
      cls_in.kind    = u8dec_pkg::K_LEAD3;
      cls_in.payload = {3'b000, byte_i[3:0]};
    end else if (byte_i[7:3] == 5'b11110) begin
      cls_in.kind    = u8dec_pkg::K_LEAD4;
      cls_in.payload = {4'b0000, byte_i[2:0]};
    end
  end

  u8dec_fifo #(
    .T     (u8dec_pkg::cls_t),
    .Depth (Depth)
  ) u_cls_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push_i),
    .wr_data_i (cls_in),
    .full_o    (full_o),
    .rd_en_i   (cls_ready_i),
    .rd_data_o (cls_o),
    .empty_o   (cls_empty)
  );

  assign cls_valid_o = !cls_empty;

endmodule

// ===== hw/rtl/u8dec_back.sv =====
// Back end: sequence state, code point assembly and the result queue.
module u8dec_back #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  u8dec_pkg::cls_t cls_i,
  input  logic            cls_valid_i,
  output logic            cls_ready_o,
  input  logic            pop_i,
  output u8dec_pkg::res_t res_o,
  output logic            empty_o
);

  logic [1:0]  pending_q, pending_d;
  logic [20:0] partial_q, partial_d;
  logic        guard_q, guard_d;
  logic        err_q, err_d;

  logic            res_full;
  logic            fire;
  logic            emit;
  logic            done;
  logic [20:0]     cp;
  u8dec_pkg::status_e status;
  logic            err_new;
  logic [20:0]     shifted;
  u8dec_pkg::res_t res_in;

  // The back end takes a class whenever the result queue has room, since
  // any byte may produce a result.
  assign fire        = cls_valid_i && !res_full;
  assign cls_ready_o = !res_full;
  assign shifted     = {partial_q[14:0], cls_i.payload[5:0]};

  always_comb begin
    pending_d = pending_q;
    partial_d = partial_q;
    guard_d   = guard_q;
    emit      = 1'b0;
    done      = cls_i.eos;
    cp        = u8dec_pkg::CpReplacement;
    status    = u8dec_pkg::ST_OK;
    if (pending_q != 2'd0) begin
      if (cls_i.kind != u8dec_pkg::K_CONT || (guard_q && cls_i.a0_set)) begin
        emit      = 1'b1;
        status    = u8dec_pkg::ST_INVALID;
        pending_d = 2'd0;
        partial_d = '0;
        guard_d   = 1'b0;
      end else if (pending_q == 2'd1) begin
        emit      = 1'b1;
        cp        = shifted;
        pending_d = 2'd0;
        partial_d = '0;
        guard_d   = 1'b0;
      end else begin
        partial_d = shifted;
        pending_d = pending_q - 2'd1;
        guard_d   = 1'b0;
      end
    end else begin
      unique case (cls_i.kind)
        u8dec_pkg::K_ASCII: begin
          emit = 1'b1;
          cp   = {14'd0, cls_i.payload};
        end
        u8dec_pkg::K_LEAD2: begin
          pending_d = 2'd1;
          partial_d = {14'd0, cls_i.payload};
        end
        u8dec_pkg::K_LEAD3: begin
          pending_d = 2'd2;
          partial_d = {14'd0, cls_i.payload};
          guard_d   = cls_i.is_ed;
        end
        u8dec_pkg::K_LEAD4: begin
          pending_d = 2'd3;
          partial_d = {14'd0, cls_i.payload};
        end
        default: begin
          emit   = 1'b1;
          status = u8dec_pkg::ST_INVALID;
        end
      endcase
    end
    // A sequence left open by the end-of-string byte is truncated.
    if (!emit && cls_i.eos) begin
      emit   = 1'b1;
      status = u8dec_pkg::ST_TRUNC;
      cp     = u8dec_pkg::CpReplacement;
    end
    err_new = err_q || (emit && status != u8dec_pkg::ST_OK);
    err_d   = err_new;
    if (emit && done) begin
      pending_d = 2'd0;
      partial_d = '0;
      guard_d   = 1'b0;
      err_d     = 1'b0;
    end
  end

  always_comb begin
    res_in.code_point   = cp;
    res_in.status       = status;
    res_in.string_valid = !err_new;
    res_in.string_done  = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
      partial_q <= '0;
      guard_q   <= 1'b0;
      err_q     <= 1'b0;
    end else if (fire) begin
      pending_q <= pending_d;
      partial_q <= partial_d;
      guard_q   <= guard_d;
      err_q     <= err_d;
    end
  end

  u8dec_fifo #(
    .T     (u8dec_pkg::res_t),
    .Depth (Depth)
  ) u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (fire && emit),
    .wr_data_i (res_in),
    .full_o    (res_full),
    .rd_en_i   (pop_i),
    .rd_data_o (res_o),
    .empty_o   (empty_o)
  );

endmodule

// ===== hw/rtl/utf8_stream_validating_decoder.sv =====
// Top level of the UTF-8 stream validating decoder.
//
//   Channel  | Direction | Handshake            | Payload
//   ---------+-----------+----------------------+------------------------------------
//   bytes    | in        | push / full          | byte_value_i, end_of_string_i
//   results  | out       | empty / pop          | code_point_o, status_o,
//            |           |                      | string_valid_o, string_done_o
//
// One byte is accepted per cycle while full is low. A byte that produces a
// result makes it visible after its transfer: the transfer writes its class
// into the class queue, and the back end then carries it through the decode state
// into the result queue once that queue has room.
// The rate of one byte per cycle is sustained while results are popped and is set
// by the decode step in the back end, which updates the sequence state once per class.
// The asynchronous active-low reset empties both queues and returns the
// decoder to the start of a string.
// When results are not popped, the result queue fills, the back end stops
// taking classes, and full rises once the class queue fills as well.
module utf8_stream_validating_decoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  byte_value_i,
  input  logic        end_of_string_i,
  output logic        empty,
  input  logic        pop,
  output logic [20:0] code_point_o,
  output logic [1:0]  status_o,
  output logic        string_valid_o,
  output logic        string_done_o
);

  u8dec_pkg::cls_t cls;
  logic            cls_valid;
  logic            cls_ready;
  u8dec_pkg::res_t res;

  // Front end: classifies each byte as it is transferred in.
  u8dec_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .byte_i      (byte_value_i),
    .eos_i       (end_of_string_i),
    .full_o      (full),
    .cls_o       (cls),
    .cls_valid_o (cls_valid),
    .cls_ready_i (cls_ready)
  );

  // Back end: tracks the open sequence and the sticky error flag.
  u8dec_back #(
    .Depth (QueueDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_i       (cls),
    .cls_valid_i (cls_valid),
    .cls_ready_o (cls_ready),
    .pop_i       (pop),
    .res_o       (res),
    .empty_o     (empty)
  );

  assign code_point_o   = res.code_point;
  assign status_o       = res.status;
  assign string_valid_o = res.string_valid;
  assign string_done_o  = res.string_done;

endmodule

// ===== hw/rtl/u8dec_chk.sv =====
// Port-level checker of the UTF-8 stream validating decoder and its bind.
module u8dec_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [20:0] code_point_o,
  input logic [1:0]  status_o,
  input logic        string_valid_o,
  input logic        string_done_o
);

  // A waiting result stays put until its transfer.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(code_point_o) && $stable(status_o)
      && $stable(string_valid_o) && $stable(string_done_o)))
    else $error("waiting result changed before its transfer");

  // Any failing result carries the replacement character and marks the string invalid.
  a_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != u8dec_pkg::ST_OK) |->
      (code_point_o == u8dec_pkg::CpReplacement && !string_valid_o))
    else $error("failing result without replacement or with valid string");

  // Truncation is only reported at the end of a string.
  a_trunc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == u8dec_pkg::ST_TRUNC) |-> string_done_o)
    else $error("truncation reported before end of string");

  // The unused status code never appears.
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o == u8dec_pkg::ST_OK || status_o == u8dec_pkg::ST_INVALID
      || status_o == u8dec_pkg::ST_TRUNC))
    else $error("undefined status code on result");

endmodule

bind utf8_stream_validating_decoder u8dec_chk u_chk (.*);
